### design/msnt_pkg.sv
// ----------------------------------------------------------------------------
// msnt_pkg
// Shared types and constants of the MIDI sustain pedal note tracker.
// ----------------------------------------------------------------------------
package msnt_pkg;

	// tracked key window
	localparam int KEYS_DEF = 61;

	// configuration port
	localparam int         PADDR_W       = 3;
	localparam logic       REG_BASE_NOTE = 1'b0;
	localparam logic [6:0] BASE_NOTE_RST = 7'd36;

	// MIDI byte codes
	localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
	localparam logic [7:0] BYTE_SENSE    = 8'hFE;
	localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
	localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
	localparam logic [3:0] STAT_CTRL     = 4'hB;
	localparam logic [6:0] CC_SUSTAIN    = 7'd64;
	localparam logic [6:0] PEDAL_THRESH  = 7'd64;

	// decoded message action
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PRESS,
		ACT_RELEASE,
		ACT_PEDAL_DOWN,
		ACT_PEDAL_UP
	} act_t;

	// reported event codes
	typedef enum logic [2:0] {
		EVT_PRESS      = 3'd0,
		EVT_RELEASE    = 3'd1,
		EVT_HELD       = 3'd2,
		EVT_DECAY      = 3'd3,
		EVT_PEDAL_DOWN = 3'd4,
		EVT_PEDAL_UP   = 3'd5
	} evt_kind_t;

	// key store operations
	typedef enum logic [2:0] {
		KOP_NONE,
		KOP_PRESS,
		KOP_HOLD,
		KOP_RELEASE,
		KOP_CLEAR
	} kop_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_DECAY,
		ST_SCAN,
		ST_SCAN_DECAY
	} seq_state_t;

	// completed message from the parser
	typedef struct packed {
		act_t       act;
		logic [6:0] note;
		logic [6:0] vel;
	} cmd_t;

	// request to the key store
	typedef struct packed {
		kop_t op;
		logic rd_en;
	} key_ctl_t;

	// key store status for the addressed slot
	typedef struct packed {
		logic hit_active;
		logic hit_waiting;
		logic any_waiting;
		logic others_waiting;
	} key_sts_t;

	// one result
	typedef struct packed {
		evt_kind_t   kind;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic        pedal_down;
		logic        by_pedal;
		logic        duration_valid;
		logic [31:0] duration_ms;
		logic        last;
	} evt_t;

endpackage

### design/msnt_if.sv
// ----------------------------------------------------------------------------
// msnt_if
// Valid/ready channels of the note tracker: MIDI byte input and event output.
// ----------------------------------------------------------------------------
interface msnt_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  midi_byte;
	logic [31:0] time_ms;

	modport source (output valid, midi_byte, time_ms, input ready);
	modport sink (input valid, midi_byte, time_ms, output ready);
endinterface

interface msnt_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [6:0]  note;
	logic [6:0]  velocity;
	logic        pedal_down;
	logic        by_pedal;
	logic        duration_valid;
	logic [31:0] duration_ms;
	logic        last;

	modport source (output valid, event_kind, note, velocity, pedal_down, by_pedal,
		duration_valid, duration_ms, last, input ready);
	modport sink (input valid, event_kind, note, velocity, pedal_down, by_pedal,
		duration_valid, duration_ms, last, output ready);
endinterface

### design/msnt_parser.sv
// ----------------------------------------------------------------------------
// msnt_parser
// Running status MIDI parser; tracks the sustain pedal and decodes note and
// pedal messages into actions.
// ----------------------------------------------------------------------------
module msnt_parser import msnt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] midi_byte,
	output cmd_t       cmd,
	output logic       sustain
);

	logic [7:0] running_q;
	logic       idx_q;
	logic [6:0] first_q;
	logic       sustain_q;

	logic       ignore_c;
	logic       is_status_c;
	logic [3:0] type_c;
	logic       msg_ok_c;
	logic       data_c;
	logic       down_c;
	logic       pedal_chg_c;

	// byte classification
	always_comb begin
		ignore_c    = (midi_byte == BYTE_CLOCK) || (midi_byte == BYTE_SENSE);
		is_status_c = midi_byte[7];
		type_c      = running_q[7:4];
		msg_ok_c    = (type_c == STAT_NOTE_OFF) || (type_c == STAT_NOTE_ON) ||
			(type_c == STAT_CTRL);
		data_c      = !ignore_c && !is_status_c && msg_ok_c;
		down_c      = midi_byte[6:0] >= PEDAL_THRESH;
		pedal_chg_c = (type_c == STAT_CTRL) && (first_q == CC_SUSTAIN) &&
			(down_c != sustain_q);
	end

	// action of a completed two-byte message
	always_comb begin
		cmd.act  = ACT_NONE;
		cmd.note = first_q;
		cmd.vel  = '0;
		if (data_c && idx_q) begin
			if (type_c == STAT_NOTE_ON && midi_byte[6:0] != 7'd0) begin
				cmd.act = ACT_PRESS;
				cmd.vel = midi_byte[6:0];
			end else if (type_c == STAT_NOTE_OFF || type_c == STAT_NOTE_ON) begin
				cmd.act = ACT_RELEASE;
			end else if (pedal_chg_c) begin
				cmd.act  = down_c ? ACT_PEDAL_DOWN : ACT_PEDAL_UP;
				cmd.note = '0;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			idx_q     <= 1'b0;
			first_q   <= '0;
			sustain_q <= 1'b0;
		end else if (in_fire && !ignore_c) begin
			if (is_status_c) begin
				running_q <= midi_byte;
				idx_q     <= 1'b0;
			end else if (msg_ok_c) begin
				if (!idx_q) begin
					first_q <= midi_byte[6:0];
					idx_q   <= 1'b1;
				end else begin
					idx_q <= 1'b0;
					if (pedal_chg_c) begin
						sustain_q <= down_c;
					end
				end
			end
		end
	end

	assign sustain = sustain_q;

endmodule

### design/msnt_key_store.sv
// ----------------------------------------------------------------------------
// msnt_key_store
// Per key active and waiting marks in flip-flops and the start time memory
// with a registered read port.
// ----------------------------------------------------------------------------
module msnt_key_store import msnt_pkg::*; #(
	parameter int KEYS = KEYS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  key_ctl_t                                    ctl,
	input  logic [((KEYS > 1) ? $clog2(KEYS) : 1)-1:0] slot,
	input  logic [31:0]                                 wtime,
	output key_sts_t                                    sts,
	output logic [31:0]                                 rd_data
);

	localparam int SLOT_W = (KEYS > 1) ? $clog2(KEYS) : 1;

	logic [KEYS-1:0] active_q;
	logic [KEYS-1:0] waiting_q;
	logic [31:0]     start_mem [KEYS];
	logic [31:0]     rd_data_q;

	logic            slot_ok_c;
	logic [KEYS-1:0] sel_c;

	// one-hot of the addressed slot
	always_comb begin
		slot_ok_c = int'(slot) < KEYS;
		sel_c     = '0;
		if (slot_ok_c) begin
			sel_c[slot] = 1'b1;
		end
	end

	// status of the addressed slot
	always_comb begin
		sts.hit_active     = |(active_q & sel_c);
		sts.hit_waiting    = |(waiting_q & sel_c);
		sts.any_waiting    = |waiting_q;
		sts.others_waiting = |(waiting_q & ~sel_c);
	end

	// key marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			waiting_q <= '0;
		end else begin
			case (ctl.op)
				KOP_PRESS: begin
					active_q  <= active_q | sel_c;
					waiting_q <= waiting_q & ~sel_c;
				end
				KOP_HOLD: begin
					waiting_q <= waiting_q | sel_c;
				end
				KOP_RELEASE: begin
					active_q <= active_q & ~sel_c;
				end
				KOP_CLEAR: begin
					active_q  <= active_q & ~sel_c;
					waiting_q <= waiting_q & ~sel_c;
				end
				default: begin
				end
			endcase
		end
	end

	// start time memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (ctl.op == KOP_PRESS) begin
			start_mem[slot[SLOT_W-1:0]] <= wtime;
		end
		if (ctl.rd_en) begin
			rd_data_q <= start_mem[slot[SLOT_W-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/msnt_seq.sv
// ----------------------------------------------------------------------------
// msnt_seq
// Event sequencer: maps actions onto key store operations, runs the pedal
// release scan and drives the registered event output.
// ----------------------------------------------------------------------------
module msnt_seq import msnt_pkg::*; #(
	parameter int KEYS = KEYS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  cmd_t                                        cmd,
	input  logic [31:0]                                 in_time,
	input  logic [6:0]                                  base,
	input  logic                                        sustain,
	output key_ctl_t                                    key_ctl,
	output logic [((KEYS > 1) ? $clog2(KEYS) : 1)-1:0] key_slot,
	output logic [31:0]                                 key_wtime,
	input  key_sts_t                                    key_sts,
	input  logic [31:0]                                 rd_data,
	msnt_evt_if.source                                  evt_out
);

	localparam int SLOT_W = (KEYS > 1) ? $clog2(KEYS) : 1;

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [SLOT_W-1:0] k_q;

	evt_kind_t         job_kind_q;
	logic [6:0]        job_note_q;
	logic [6:0]        job_vel_q;
	logic [31:0]       job_time_q;
	logic              job_dvalid_q;
	logic              job_decay_q;

	logic              out_valid_q;
	evt_t              out_q;

	logic              in_fire;
	logic              space;
	logic [7:0]        diff_c;
	logic              tracked_c;
	logic [SLOT_W-1:0] slot_c;
	logic              held_c;
	logic              emit_en;
	evt_t              emit_c;
	logic [31:0]       dur_c;

	assign in_fire = in_valid && in_ready;
	assign space   = !out_valid_q || evt_out.ready;

	// key slot of the message note
	always_comb begin
		diff_c    = {1'b0, cmd.note} - {1'b0, base};
		tracked_c = !diff_c[7] && (diff_c[6:0] < 7'(KEYS));
		slot_c    = diff_c[SLOT_W-1:0];
		held_c    = tracked_c && sustain;
	end

	assign key_slot  = (state_q == ST_IDLE) ? slot_c : k_q;
	assign key_wtime = in_time;
	assign dur_c     = job_time_q - rd_data;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && cmd.act != ACT_NONE) begin
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (space) begin
					if (job_decay_q) begin
						state_d = ST_DECAY;
					end else if (job_kind_q == EVT_PEDAL_UP && key_sts.any_waiting) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DECAY: begin
				if (space) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (key_sts.hit_waiting) begin
					state_d = ST_SCAN_DECAY;
				end
			end
			ST_SCAN_DECAY: begin
				if (space) begin
					state_d = key_sts.others_waiting ? ST_SCAN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs: key store requests and the result to emit
	always_comb begin
		in_ready      = 1'b0;
		key_ctl.op    = KOP_NONE;
		key_ctl.rd_en = 1'b0;
		emit_en       = 1'b0;
		emit_c        = '{kind: EVT_DECAY, note: job_note_q, velocity: '0,
			pedal_down: sustain, by_pedal: 1'b0, duration_valid: 1'b0,
			duration_ms: '0, last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire && tracked_c) begin
					case (cmd.act)
						ACT_PRESS: key_ctl.op = KOP_PRESS;
						ACT_RELEASE: begin
							if (sustain) begin
								key_ctl.op = KOP_HOLD;
							end else begin
								key_ctl.op    = KOP_RELEASE;
								key_ctl.rd_en = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FIRST: begin
				emit_en         = 1'b1;
				emit_c.kind     = job_kind_q;
				emit_c.velocity = job_vel_q;
				emit_c.last     = !job_decay_q &&
					!(job_kind_q == EVT_PEDAL_UP && key_sts.any_waiting);
			end
			ST_DECAY: begin
				emit_en               = 1'b1;
				emit_c.duration_valid = job_dvalid_q;
				emit_c.duration_ms    = job_dvalid_q ? dur_c : '0;
			end
			ST_SCAN: begin
				key_ctl.rd_en = 1'b1;
			end
			ST_SCAN_DECAY: begin
				emit_en               = 1'b1;
				emit_c.note           = base + 7'(k_q);
				emit_c.by_pedal       = 1'b1;
				emit_c.duration_valid = key_sts.hit_active;
				emit_c.duration_ms    = key_sts.hit_active ? dur_c : '0;
				emit_c.last           = !key_sts.others_waiting;
				if (space) begin
					key_ctl.op = KOP_CLEAR;
				end
			end
			default: begin
			end
		endcase
	end

	// state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIRST) begin
				k_q <= '0;
			end else if (state_q == ST_SCAN && !key_sts.hit_waiting) begin
				k_q <= k_q + 1'b1;
			end else if (state_q == ST_SCAN_DECAY && space) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// job captured with the byte transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			job_note_q   <= cmd.note;
			job_vel_q    <= cmd.vel;
			job_time_q   <= in_time;
			job_dvalid_q <= tracked_c && key_sts.hit_active;
			job_decay_q  <= (cmd.act == ACT_RELEASE) && !held_c;
			case (cmd.act)
				ACT_RELEASE:    job_kind_q <= held_c ? EVT_HELD : EVT_RELEASE;
				ACT_PEDAL_DOWN: job_kind_q <= EVT_PEDAL_DOWN;
				ACT_PEDAL_UP:   job_kind_q <= EVT_PEDAL_UP;
				default:        job_kind_q <= EVT_PRESS;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (space) begin
			out_valid_q <= emit_en;
		end
	end

	always_ff @(posedge clk) begin
		if (space && emit_en) begin
			out_q <= emit_c;
		end
	end

	assign evt_out.valid          = out_valid_q;
	assign evt_out.event_kind     = out_q.kind;
	assign evt_out.note           = out_q.note;
	assign evt_out.velocity       = out_q.velocity;
	assign evt_out.pedal_down     = out_q.pedal_down;
	assign evt_out.by_pedal       = out_q.by_pedal;
	assign evt_out.duration_valid = out_q.duration_valid;
	assign evt_out.duration_ms    = out_q.duration_ms;
	assign evt_out.last           = out_q.last;

	// a scan decay only ever targets a waiting key
	a_scan_hits_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN_DECAY |-> key_sts.hit_waiting)
		else $error("scan decay on a key that is not waiting");

	// the last result of a byte returns the sequencer to idle
	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_en && space && emit_c.last) |=> state_q == ST_IDLE)
		else $error("sequencer busy after last result");

	// the scan counter stays inside the key window
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SCAN_DECAY) |-> int'(k_q) < KEYS)
		else $error("scan counter past the key window");

endmodule

### design/midi_sustain_note_tracker.sv
// ----------------------------------------------------------------------------
// midi_sustain_note_tracker
// Parses MIDI bytes and reports key press, release, decay and sustain pedal
// events for a window of tracked keys.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// midi_in   in         valid / ready      midi_byte, time_ms
// evt_out   out        valid / ready      event_kind .. duration_ms, last
// apb       in         psel / penable     paddr, pwdata, prdata (base_note)
//
// A byte transaction is taken when the sequencer is idle; each result then
// leaves the output register one per cycle while evt_out.ready is high.
// A release gives a release and a decay result, or a held result under the
// pedal; a pedal release gives the pedal-up result, then scans the key store
// one key per cycle, held while a waiting key's decay result waits, and
// stops after the last waiting key. Reset clears the marks at once, no
// clearing pass; start times are undefined until a key is pressed.
// Low evt_out.ready holds the output register and stalls the sequencer.
//
module midi_sustain_note_tracker import msnt_pkg::*; #(
	parameter int KEYS = KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	msnt_in_if.sink            midi_in,
	msnt_evt_if.source         evt_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int SLOT_W = (KEYS > 1) ? $clog2(KEYS) : 1;

	logic [6:0]        base_q;
	logic              in_ready;
	logic              in_fire;
	cmd_t              cmd;
	logic              sustain;
	key_ctl_t          key_ctl;
	key_sts_t          key_sts;
	logic [SLOT_W-1:0] key_slot;
	logic [31:0]       key_wtime;
	logic [31:0]       rd_data;
	logic              reg_hit;

	// configuration register
	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1] == REG_BASE_NOTE;
	assign prdata  = reg_hit ? {25'd0, base_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_NOTE_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			base_q <= pwdata[6:0];
		end
	end

	assign midi_in.ready = in_ready;
	assign in_fire       = midi_in.valid && in_ready;

	msnt_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.midi_byte (midi_in.midi_byte),
		.cmd       (cmd),
		.sustain   (sustain)
	);

	msnt_key_store #(
		.KEYS (KEYS)
	) u_key_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (key_ctl),
		.slot    (key_slot),
		.wtime   (key_wtime),
		.sts     (key_sts),
		.rd_data (rd_data)
	);

	msnt_seq #(
		.KEYS (KEYS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (midi_in.valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.in_time   (midi_in.time_ms),
		.base      (base_q),
		.sustain   (sustain),
		.key_ctl   (key_ctl),
		.key_slot  (key_slot),
		.key_wtime (key_wtime),
		.key_sts   (key_sts),
		.rd_data   (rd_data),
		.evt_out   (evt_out)
	);

endmodule

### sim/tb_midi_sustain_note_tracker.sv
// ----------------------------------------------------------------------------
// tb_midi_sustain_note_tracker
// Streams MIDI bytes with timestamps into the note tracker and checks every
// reported event against a cycle-free prediction of the key, pedal and
// running status state, under several base note settings and flow patterns.
// ----------------------------------------------------------------------------
module tb_midi_sustain_note_tracker;
	import msnt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS          = KEYS_DEF;
	localparam int SETTLE_CYCLES = 3 * KEYS + 40;
	localparam int WDOG_LIMIT    = 5000;
	localparam int MAX_REPORTS   = 10;
	localparam int HOLD_CYCLES   = 600;

	localparam logic [PADDR_W-1:0] BASE_NOTE_ADDR = PADDR_W'(4 * int'(REG_BASE_NOTE));

	// message types the tracker does not act on
	localparam logic [3:0] STAT_POLY_AT = 4'hA;
	localparam logic [3:0] STAT_PROG    = 4'hC;
	localparam logic [3:0] STAT_CHAN_AT = 4'hD;
	localparam logic [3:0] STAT_BEND    = 4'hE;
	localparam logic [7:0] SYS_EXCL     = 8'hF0;
	localparam logic [7:0] SYS_EOX      = 8'hF7;

	typedef struct packed {
		logic [7:0]  mbyte;
		logic [31:0] tms;
	} midi_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	msnt_in_if  midi_ch ();
	msnt_evt_if evt_ch ();

	midi_sustain_note_tracker #(.KEYS(KEYS)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.midi_in (midi_ch),
		.evt_out (evt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted tracker state
	logic [6:0]  base_q;
	logic [7:0]  run_stat;
	logic        data_hi;
	logic [6:0]  first_q;
	logic        pedal_q;
	logic        key_on [KEYS];
	logic        key_wait [KEYS];
	logic [31:0] key_t0 [KEYS];

	evt_t       pending_events[$];
	midi_item_t byte_q[$];
	midi_item_t tx_item;
	logic       tx_busy = 1'b0;
	int         fail_cnt = 0;
	int         idle_cycles = 0;

	// flow control knobs
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	// stimulus generator state
	logic [31:0] stamp;
	logic [7:0]  gen_stat;
	int          gen_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic void add_expected(evt_kind_t k, logic [6:0] n, logic [6:0] v,
		logic byp, logic dv, logic [31:0] dur);
		evt_t e;
		e.kind = k;
		e.note = n;
		e.velocity = v;
		e.pedal_down = pedal_q;
		e.by_pedal = byp;
		e.duration_valid = dv;
		e.duration_ms = dv ? dur : 32'd0;
		e.last = 1'b0;
		pending_events.push_back(e);
	endfunction

	function automatic int key_slot(logic [6:0] n);
		if (int'(n) < int'(base_q) || int'(n) - int'(base_q) >= KEYS)
			return -1;
		return int'(n) - int'(base_q);
	endfunction

	function automatic void expect_decay(logic [6:0] n, int s, logic byp, logic [31:0] now);
		logic dv;
		logic [31:0] dur;
		dv = 1'b0;
		dur = '0;
		if (s >= 0) begin
			dv = key_on[s];
			if (dv)
				dur = now - key_t0[s];
			key_on[s] = 1'b0;
		end
		add_expected(EVT_DECAY, n, 7'd0, byp, dv, dur);
	endfunction

	function automatic void track_midi_byte(logic [7:0] b, logic [31:0] now);
		int nres;
		int s;
		logic [3:0] typ;
		logic [6:0] d1;
		logic down;
		evt_t tail;
		nres = pending_events.size();
		if (b == BYTE_CLOCK || b == BYTE_SENSE)
			return;
		if (b[7]) begin
			run_stat = b;
			data_hi = 1'b0;
			return;
		end
		if (run_stat == 8'h00)
			return;
		typ = run_stat[7:4];
		if (typ != STAT_NOTE_OFF && typ != STAT_NOTE_ON && typ != STAT_CTRL)
			return;
		if (!data_hi) begin
			first_q = b[6:0];
			data_hi = 1'b1;
			return;
		end
		data_hi = 1'b0;
		d1 = first_q;

		if (typ == STAT_NOTE_ON && b != 8'h00) begin
			// press, tracked keys restart their timer
			s = key_slot(d1);
			if (s >= 0) begin
				key_on[s] = 1'b1;
				key_t0[s] = now;
				key_wait[s] = 1'b0;
			end
			add_expected(EVT_PRESS, d1, b[6:0], 1'b0, 1'b0, '0);
		end else if (typ == STAT_NOTE_OFF || typ == STAT_NOTE_ON) begin
			// release, held by the pedal only inside the window
			s = key_slot(d1);
			if (s >= 0 && pedal_q) begin
				key_wait[s] = 1'b1;
				add_expected(EVT_HELD, d1, 7'd0, 1'b0, 1'b0, '0);
			end else begin
				add_expected(EVT_RELEASE, d1, 7'd0, 1'b0, 1'b0, '0);
				expect_decay(d1, s, 1'b0, now);
			end
		end else if (d1 == CC_SUSTAIN) begin
			// sustain pedal, only state changes are reported
			down = (b[6:0] >= PEDAL_THRESH);
			if (down != pedal_q) begin
				pedal_q = down;
				if (down) begin
					add_expected(EVT_PEDAL_DOWN, 7'd0, 7'd0, 1'b0, 1'b0, '0);
				end else begin
					add_expected(EVT_PEDAL_UP, 7'd0, 7'd0, 1'b0, 1'b0, '0);
					for (int k = 0; k < KEYS; k++) begin
						if (key_wait[k]) begin
							key_wait[k] = 1'b0;
							expect_decay(base_q + 7'(k), k, 1'b1, now);
						end
					end
				end
			end
		end

		if (pending_events.size() > nres) begin
			tail = pending_events.pop_back();
			tail.last = 1'b1;
			pending_events.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic string evt_str(evt_t e);
		return $sformatf("kind %0d note %0d vel %0d pedal %0b byp %0b dv %0b dur %0d last %0b",
			e.kind, e.note, e.velocity, e.pedal_down, e.by_pedal, e.duration_valid,
			e.duration_ms, e.last);
	endfunction

	function automatic void check_event();
		evt_t want;
		evt_t got;
		got.kind = evt_kind_t'(evt_ch.event_kind);
		got.note = evt_ch.note;
		got.velocity = evt_ch.velocity;
		got.pedal_down = evt_ch.pedal_down;
		got.by_pedal = evt_ch.by_pedal;
		got.duration_valid = evt_ch.duration_valid;
		got.duration_ms = evt_ch.duration_ms;
		got.last = evt_ch.last;
		if (pending_events.size() == 0) begin
			if (fail_cnt < MAX_REPORTS)
				$display("%0t: unexpected event: %s", $realtime, evt_str(got));
			fail_cnt++;
			return;
		end
		want = pending_events.pop_front();
		if (got.kind !== want.kind || got.note !== want.note ||
			got.velocity !== want.velocity || got.pedal_down !== want.pedal_down ||
			got.by_pedal !== want.by_pedal || got.duration_valid !== want.duration_valid ||
			got.duration_ms !== want.duration_ms || got.last !== want.last) begin
			if (fail_cnt < MAX_REPORTS) begin
				$display("%0t: event mismatch", $realtime);
				$display("  expected %s", evt_str(want));
				$display("  actual   %s", evt_str(got));
			end
			fail_cnt++;
		end
	endfunction

	// transactions on both channels, checked before the new byte is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready)
				check_event();
			if (midi_ch.valid && midi_ch.ready) begin
				track_midi_byte(midi_ch.midi_byte, midi_ch.time_ms);
				tx_busy = 1'b0;
			end
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			midi_ch.valid <= 1'b0;
		end else if (!tx_busy) begin
			if (byte_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				tx_item = byte_q.pop_front();
				tx_busy = 1'b1;
				midi_ch.valid <= 1'b1;
				midi_ch.midi_byte <= tx_item.mbyte;
				midi_ch.time_ms <= tx_item.tms;
			end else begin
				midi_ch.valid <= 1'b0;
			end
		end
	end

	// event receiver with random stalls and long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_ch.ready <= 1'b0;
		end else if (hold_ack != hold_req) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES;
			evt_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			evt_ch.ready <= 1'b0;
		end else begin
			evt_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((midi_ch.valid && midi_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
				(psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
				$display("tb_midi_sustain_note_tracker failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic add_byte(logic [7:0] b);
		midi_item_t it;
		it.mbyte = b;
		it.tms = stamp;
		byte_q.push_back(it);
		if (b != BYTE_CLOCK && b != BYTE_SENSE)
			gen_count++;
		stamp = stamp + $urandom_range(0, 250);
	endtask

	// data byte, now and then preceded by a realtime byte
	task automatic add_data(logic [6:0] d);
		if ($urandom_range(0, 11) == 0)
			add_byte($urandom_range(0, 1) ? BYTE_CLOCK : BYTE_SENSE);
		add_byte({1'b0, d});
	endtask

	// status byte, skipped at times to use running status
	task automatic add_status(logic [7:0] st);
		if (st != gen_stat || $urandom_range(0, 3) == 0)
			add_byte(st);
		gen_stat = st;
	endtask

	function automatic logic [6:0] pick_note();
		int r;
		int room;
		r = $urandom_range(0, 99);
		room = 127 - int'(base_q);
		if (r < 50)
			return base_q + 7'($urandom_range(0, (room < 11) ? room : 11));
		if (r < 85)
			return base_q + 7'($urandom_range(0, (room < KEYS - 1) ? room : KEYS - 1));
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic logic [6:0] pedal_value(logic down);
		return down ? 7'($urandom_range(64, 127)) : 7'($urandom_range(0, 63));
	endfunction

	task automatic gen_message();
		int r;
		int n;
		int cc;
		logic [3:0] ch;
		logic [7:0] st;
		logic [6:0] chord [8];
		ch = ($urandom_range(0, 3) != 0) ? 4'h0 : 4'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 29) == 0)
			stamp = $urandom();
		if (r < 28) begin
			add_status({STAT_NOTE_ON, ch});
			add_data(pick_note());
			add_data(7'($urandom_range(1, 127)));
		end else if (r < 46) begin
			add_status({STAT_NOTE_OFF, ch});
			add_data(pick_note());
			add_data(7'($urandom_range(0, 127)));
		end else if (r < 52) begin
			add_status({STAT_NOTE_ON, ch});
			add_data(pick_note());
			add_data(7'd0);
		end else if (r < 66) begin
			add_status({STAT_CTRL, ch});
			add_data(CC_SUSTAIN);
			add_data(pedal_value($urandom_range(0, 1)));
		end else if (r < 72) begin
			// some other controller
			cc = $urandom_range(0, 126);
			if (cc >= int'(CC_SUSTAIN))
				cc++;
			add_status({STAT_CTRL, ch});
			add_data(7'(cc));
			add_data(7'($urandom_range(0, 127)));
		end else if (r < 78) begin
			// messages the tracker does not act on
			case ($urandom_range(0, 5))
				0: begin st = {STAT_POLY_AT, ch}; n = 2; end
				1: begin st = {STAT_PROG, ch}; n = 1; end
				2: begin st = {STAT_CHAN_AT, ch}; n = 1; end
				3: begin st = {STAT_BEND, ch}; n = 2; end
				4: begin st = SYS_EXCL; n = $urandom_range(0, 3); end
				default: begin st = 8'($urandom_range(8'hF1, 8'hFF)); n = $urandom_range(0, 2); end
			endcase
			add_byte(st);
			for (int i = 0; i < n; i++)
				add_data(7'($urandom_range(0, 127)));
			if (st == SYS_EXCL)
				add_byte(SYS_EOX);
			gen_stat = 8'h00;
		end else if (r < 83) begin
			// chord under the pedal
			n = $urandom_range(2, 8);
			add_status({STAT_CTRL, ch});
			add_data(CC_SUSTAIN);
			add_data(pedal_value(1'b1));
			for (int i = 0; i < n; i++) begin
				chord[i] = pick_note();
				if ($urandom_range(0, 4) != 0) begin
					add_status({STAT_NOTE_ON, ch});
					add_data(chord[i]);
					add_data(7'($urandom_range(1, 127)));
				end
			end
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 1)) begin
					add_status({STAT_NOTE_OFF, ch});
					add_data(chord[i]);
					add_data(7'($urandom_range(0, 127)));
				end else begin
					add_status({STAT_NOTE_ON, ch});
					add_data(chord[i]);
					add_data(7'd0);
				end
			end
			add_status({STAT_CTRL, ch});
			add_data(CC_SUSTAIN);
			add_data(pedal_value(1'b0));
		end else if (r < 89) begin
			// message cut short by a new status
			case ($urandom_range(0, 2))
				0: add_byte({STAT_NOTE_ON, ch});
				1: add_byte({STAT_NOTE_OFF, ch});
				default: add_byte({STAT_CTRL, ch});
			endcase
			if ($urandom_range(0, 3) != 0)
				add_data(7'($urandom_range(0, 127)));
			gen_stat = 8'h00;
		end else begin
			add_byte(8'($urandom_range(0, 255)));
			gen_stat = 8'h00;
		end
	endtask

	task automatic run_random(int count);
		gen_count = 0;
		while (gen_count < count)
			gen_message();
	endtask

	// wait for every transaction and result, then for the pedal scan to finish
	task automatic drain_and_settle();
		while (byte_q.size() != 0 || tx_busy || pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [31:0] wdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= BASE_NOTE_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (!wr && prdata[6:0] !== base_q) begin
			if (fail_cnt < MAX_REPORTS)
				$display("%0t: base_note readback: expected %0d actual %0d",
					$realtime, base_q, prdata[6:0]);
			fail_cnt++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_base_note(logic [6:0] v);
		logic [31:0] wd;
		wd = $urandom();
		wd[6:0] = v;
		apb_access(1'b1, wd);
		base_q = v;
		apb_access(1'b0, '0);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [6:0] lo;
		logic [6:0] hi;

		arst_n = 1'b0;
		midi_ch.valid = 1'b0;
		midi_ch.midi_byte = '0;
		midi_ch.time_ms = '0;
		evt_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		base_q = BASE_NOTE_RST;
		run_stat = 8'h00;
		data_hi = 1'b0;
		first_q = '0;
		pedal_q = 1'b0;
		for (int k = 0; k < KEYS; k++) begin
			key_on[k] = 1'b0;
			key_wait[k] = 1'b0;
		end
		gen_stat = 8'h00;
		stamp = '0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// reset value of the window base
		apb_access(1'b0, '0);

		// directed: window edges, outside keys, pedal hold, timestamp wrap
		lo = base_q;
		hi = base_q + 7'(KEYS - 1);
		add_byte(8'h3C);
		add_byte(BYTE_CLOCK);
		add_byte(BYTE_SENSE);
		add_byte({STAT_NOTE_ON, 4'h0});
		add_byte({1'b0, lo});
		add_byte(8'd127);
		add_byte({1'b0, hi});
		stamp = 32'hFFFF_FFFF;
		add_byte(8'd1);
		add_byte(8'd0);
		add_byte(8'd64);
		add_byte(8'd127);
		add_byte(8'd0);
		add_byte({STAT_NOTE_OFF, 4'hF});
		add_byte({1'b0, lo});
		add_byte(8'd0);
		add_byte({STAT_CTRL, 4'h3});
		add_byte({1'b0, CC_SUSTAIN});
		add_byte(8'd127);
		add_byte({1'b0, CC_SUSTAIN});
		add_byte(8'd64);
		add_byte({STAT_NOTE_OFF, 4'h0});
		add_byte({1'b0, hi});
		add_byte(8'd64);
		add_byte({STAT_CTRL, 4'h0});
		add_byte({1'b0, CC_SUSTAIN});
		add_byte(8'd63);
		gen_stat = 8'h00;

		// no idling
		run_random(60);
		drain_and_settle();

		// lowest window, sparse input
		set_base_note(7'd0);
		tx_idle_pct = 81;
		rx_stall_pct = 0;
		run_random(60);
		drain_and_settle();

		// highest window, slow receiver
		set_base_note(7'd127);
		tx_idle_pct = 0;
		rx_stall_pct = 81;
		run_random(60);
		drain_and_settle();

		// window ending at the top note, both sides idle
		set_base_note(7'(KEYS_DEF > 127 ? 0 : 127 - (KEYS - 1)));
		tx_idle_pct = 21;
		rx_stall_pct = 21;
		run_random(60);
		drain_and_settle();

		// back pressure: every tracked key held, then released by the pedal
		set_base_note(7'($urandom_range(0, 127 - (KEYS - 1))));
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req++;
		add_byte({STAT_CTRL, 4'h0});
		add_data(CC_SUSTAIN);
		add_data(7'd127);
		add_byte({STAT_NOTE_OFF, 4'h0});
		for (int k = 0; k < KEYS; k++) begin
			add_data(base_q + 7'(k));
			add_data(7'($urandom_range(0, 127)));
		end
		add_byte({STAT_CTRL, 4'h0});
		add_data(CC_SUSTAIN);
		add_data(7'd0);
		gen_stat = 8'h00;

		// sender waits for every result before going on
		while (byte_q.size() != 0 || tx_busy || pending_events.size() != 0)
			@(posedge clk);
		tx_idle_pct = 21;
		rx_stall_pct = 21;
		run_random(60);
		drain_and_settle();

		if (fail_cnt == 0)
			$display("tb_midi_sustain_note_tracker passed");
		else
			$display("tb_midi_sustain_note_tracker failed");
		$finish;
	end

endmodule
